// ===== rtl/core/sparse_matrix_triplet_transpose_core_defines.svh =====
// Assertion macros for the sparse matrix triplet transpose core.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef SPARSE_MATRIX_TRIPLET_TRANSPOSE_CORE_DEFINES_SVH
`define SPARSE_MATRIX_TRIPLET_TRANSPOSE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMTT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smtt same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SMTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smtt next-cycle check failed");

`endif

// ===== rtl/core/smtt_pkg.sv =====
// Shared types, codes and helpers of the sparse matrix triplet transpose core.
// Depends on nothing; every module and interface of the core imports it.
package smtt_pkg;

    localparam int DIM_W       = 7;
    localparam int ELEM_W      = 32;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int MAX_DIM_DEF = 64;
    localparam int VALUE_W_DEF = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_LOAD = 2'd0;
    localparam t_phase PH_ROW  = 2'd1;
    localparam t_phase PH_COL  = 2'd2;

    typedef struct packed {
        logic load;
        logic hdr0;
        logic div_start;
        logic init_work;
        logic rd;
        logic adv;
        logic col;
        logic any_init;
        logic stage_elem;
        logic stage_hdr1;
        logic hdr_last;
        logic mark_last;
        logic phase2;
        logic clear;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   load_full;
        logic   div_done;
        logic   at_end;
        logic   in_range;
        logic   nonzero;
        logic   out_free;
    } t_stat;

    // Zero acts as one, anything above the largest dimension acts as the largest.
    function automatic logic [DIM_W-1:0] f_eff_dim(input logic [DIM_W-1:0] v,
                                                    input int max_dim);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > max_dim) begin
            res = DIM_W'(max_dim);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/smtt_in_if.sv =====
// Input channel of the triplet transpose core: valid/ready plus the request payload.
// Depends on smtt_pkg.
interface smtt_in_if import smtt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, output op, output elem_value, input ready);
    modport sink   (input valid, input op, input elem_value, output ready);
endinterface

// ===== rtl/core/smtt_out_if.sv =====
// Output channel of the triplet transpose core: valid/ready plus one result triple.
// Depends on smtt_pkg.
interface smtt_out_if import smtt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     list_id;
    logic                     is_header;
    logic [DIM_W-1:0]         first_coord;
    logic [DIM_W-1:0]         second_coord;
    logic signed [ELEM_W-1:0] entry_value;
    logic                     last;

    modport source (output valid, output list_id, output is_header, output first_coord,
                    output second_coord, output entry_value, output last, input ready);
    modport sink   (input valid, input list_id, input is_header, input first_coord,
                    input second_coord, input entry_value, input last, output ready);
endinterface

// ===== rtl/core/smtt_div.sv =====
// Serial restoring divider, one quotient bit per cycle; splits a scan position into
// major and minor coordinates. Depends on smtt_pkg.
module smtt_div import smtt_pkg::*; #(
    parameter int DIVIDEND_W = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIM_W-1:0]      i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIM_W-1:0]      o_remainder,
    output logic                  o_done
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIM_W-1:0]      r_rem;
    logic [DIM_W:0]        rem_sh;
    logic                  fits;
    logic [DIM_W:0]        rem_sub;

    assign rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits    = rem_sh >= {1'b0, i_divisor};
    assign rem_sub = rem_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            // shift the next dividend bit in, keep the partial remainder below the divisor
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = (r_cnt == '0);
endmodule

// ===== rtl/core/smtt_dp.sv =====
// Datapath of the triplet transpose core: element store, load and scan counters,
// result staging and output register. Depends on smtt_pkg and smtt_div.
module smtt_dp import smtt_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [DIM_W-1:0]         i_num_rows,
    input  logic [DIM_W-1:0]         i_num_cols,
    input  logic signed [ELEM_W-1:0] i_elem_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_list_id,
    output logic                     o_is_header,
    output logic [DIM_W-1:0]         o_first_coord,
    output logic [DIM_W-1:0]         o_second_coord,
    output logic signed [ELEM_W-1:0] o_entry_value,
    output logic                     o_last
);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int PROD_W = 2 * DIM_W;
    localparam int CMP_W  = (POS_W > PROD_W) ? POS_W : PROD_W;
    localparam logic signed [63:0] V_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] V_LO = -V_HI - 64'sd1;

    logic [DIM_W-1:0]  rows_eff, cols_eff, minor_dim, div_by;
    logic [PROD_W-1:0] total, col_prod;
    logic [CMP_W-1:0]  total_x, load_x, pos_x, addr_x, limit_x, bound_x;
    logic [ADDR_W-1:0] rd_addr;
    logic              load_full, do_load;

    logic signed [63:0]            elem_x;
    logic signed [VALUE_WIDTH-1:0] elem_sat;

    logic [POS_W-1:0]  r_load_pos, r_nz, r_scan, r_w_pos;
    t_phase            r_phase;
    logic [DIM_W-1:0]  r_w_min, r_w_maj;
    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd_data;

    logic                     r_stg_list, r_stg_hdr, r_stg_last;
    logic [DIM_W-1:0]         r_stg_first, r_stg_second;
    logic signed [ELEM_W-1:0] r_stg_value;

    logic                     r_out_valid, r_out_list, r_out_hdr, r_out_last;
    logic [DIM_W-1:0]         r_out_first, r_out_second;
    logic signed [ELEM_W-1:0] r_out_value;

    logic [POS_W-1:0] div_quo;
    logic [DIM_W-1:0] div_rem;
    logic             div_done;

    assign rows_eff = f_eff_dim(i_num_rows, MAX_DIM);
    assign cols_eff = f_eff_dim(i_num_cols, MAX_DIM);
    assign total    = PROD_W'(rows_eff) * PROD_W'(cols_eff);
    assign col_prod = PROD_W'(r_w_min) * PROD_W'(cols_eff);

    assign total_x = CMP_W'(total);
    assign load_x  = CMP_W'(r_load_pos);
    assign pos_x   = CMP_W'(r_w_pos);
    assign addr_x  = CMP_W'(col_prod) + CMP_W'(r_w_maj);
    assign limit_x = (total_x < load_x) ? total_x : load_x;
    assign bound_x = i_cmd.col ? total_x : limit_x;

    assign load_full = load_x >= total_x;
    assign do_load   = i_cmd.load && (r_phase == PH_LOAD) && !load_full;
    assign minor_dim = i_cmd.col ? rows_eff : cols_eff;
    assign div_by    = (r_phase == PH_COL) ? rows_eff : cols_eff;
    assign rd_addr   = i_cmd.col ? addr_x[ADDR_W-1:0] : r_w_pos[ADDR_W-1:0];

    // clamp the incoming value to the stored width
    assign elem_x = 64'(i_elem_value);
    always_comb begin
        if (elem_x > V_HI) begin
            elem_sat = VALUE_WIDTH'(V_HI);
        end else if (elem_x < V_LO) begin
            elem_sat = VALUE_WIDTH'(V_LO);
        end else begin
            elem_sat = VALUE_WIDTH'(elem_x);
        end
    end

    smtt_div #(
        .DIVIDEND_W (POS_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_scan),
        .i_divisor   (div_by),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    // element store: one write port for loads, one registered read port for scans
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[r_load_pos[ADDR_W-1:0]] <= elem_sat;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_nz       <= '0;
            r_phase    <= PH_LOAD;
            r_scan     <= '0;
        end else begin
            priority if (i_cmd.clear) begin
                r_load_pos <= '0;
                r_nz       <= '0;
                r_phase    <= PH_LOAD;
                r_scan     <= '0;
            end else if (i_cmd.hdr0) begin
                r_phase <= PH_ROW;
                r_scan  <= '0;
            end else if (i_cmd.phase2) begin
                r_phase <= PH_COL;
                r_scan  <= '0;
            end else if (i_cmd.stage_elem) begin
                r_scan <= r_w_pos + POS_W'(1);
            end else if (do_load) begin
                r_load_pos <= r_load_pos + POS_W'(1);
                if (elem_sat != '0) begin
                    r_nz <= r_nz + POS_W'(1);
                end
            end
        end
    end

    // working scan counters: linear position plus minor/major coordinates
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.init_work) begin
            r_w_pos <= r_scan;
            r_w_maj <= DIM_W'(div_quo);
            r_w_min <= div_rem;
        end else if (i_cmd.any_init) begin
            r_w_pos <= '0;
            r_w_maj <= '0;
            r_w_min <= '0;
        end else if (i_cmd.adv) begin
            r_w_pos <= r_w_pos + POS_W'(1);
            if (r_w_min == minor_dim - DIM_W'(1)) begin
                r_w_min <= '0;
                r_w_maj <= r_w_maj + DIM_W'(1);
            end else begin
                r_w_min <= r_w_min + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.hdr0) begin
            r_stg_list   <= 1'b0;
            r_stg_hdr    <= 1'b1;
            r_stg_first  <= rows_eff;
            r_stg_second <= cols_eff;
            r_stg_value  <= ELEM_W'(r_nz);
            r_stg_last   <= 1'b0;
        end else if (i_cmd.stage_hdr1) begin
            r_stg_list   <= 1'b1;
            r_stg_hdr    <= 1'b1;
            r_stg_first  <= cols_eff;
            r_stg_second <= rows_eff;
            r_stg_value  <= ELEM_W'(r_nz);
            r_stg_last   <= i_cmd.hdr_last;
        end else if (i_cmd.stage_elem) begin
            r_stg_list   <= i_cmd.col;
            r_stg_hdr    <= 1'b0;
            r_stg_first  <= r_w_maj;
            r_stg_second <= r_w_min;
            r_stg_value  <= ELEM_W'(r_rd_data);
            r_stg_last   <= 1'b0;
        end else if (i_cmd.mark_last) begin
            r_stg_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_list   <= r_stg_list;
            r_out_hdr    <= r_stg_hdr;
            r_out_first  <= r_stg_first;
            r_out_second <= r_stg_second;
            r_out_value  <= r_stg_value;
            r_out_last   <= r_stg_last;
        end
    end

    assign o_stat.phase     = r_phase;
    assign o_stat.load_full = load_full;
    assign o_stat.div_done  = div_done;
    assign o_stat.at_end    = pos_x >= bound_x;
    assign o_stat.in_range  = !i_cmd.col || (addr_x < load_x);
    assign o_stat.nonzero   = r_rd_data != '0;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_list_id      = r_out_list;
    assign o_is_header    = r_out_hdr;
    assign o_first_coord  = r_out_first;
    assign o_second_coord = r_out_second;
    assign o_entry_value  = r_out_value;
    assign o_last         = r_out_last;
endmodule

// ===== rtl/core/smtt_ctrl.sv =====
// Controller of the triplet transpose core: sequences loads, header steps and the
// row-major and column-major store scans. Depends on smtt_pkg.
module smtt_ctrl import smtt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV     = 4'd1;
    localparam logic [3:0] S_ROW_RD  = 4'd2;
    localparam logic [3:0] S_ROW_CHK = 4'd3;
    localparam logic [3:0] S_ANY_RD  = 4'd4;
    localparam logic [3:0] S_ANY_CHK = 4'd5;
    localparam logic [3:0] S_COL_RD  = 4'd6;
    localparam logic [3:0] S_COL_CHK = 4'd7;
    localparam logic [3:0] S_NXT_RD  = 4'd8;
    localparam logic [3:0] S_NXT_CHK = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    logic [3:0] r_state, n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        unique case (i_stat.phase)
                            PH_LOAD: begin
                                if (i_stat.load_full) begin
                                    cmd.hdr0 = 1'b1;
                                    n_state  = S_EMIT;
                                end
                            end
                            PH_ROW, PH_COL: begin
                                cmd.div_start = 1'b1;
                                n_state       = S_DIV;
                            end
                            default: cmd.clear = 1'b1;
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    cmd.init_work = 1'b1;
                    n_state = (i_stat.phase == PH_COL) ? S_COL_RD : S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                if (i_stat.at_end) begin
                    // triplet list done: check the whole store for any nonzero
                    cmd.any_init = 1'b1;
                    n_state      = S_ANY_RD;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_ROW_CHK;
                end
            end
            S_ROW_CHK: begin
                if (i_stat.nonzero) begin
                    cmd.stage_elem = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    cmd.adv = 1'b1;
                    n_state = S_ROW_RD;
                end
            end
            S_ANY_RD: begin
                if (i_stat.at_end) begin
                    cmd.stage_hdr1 = 1'b1;
                    cmd.hdr_last   = 1'b1;
                    cmd.clear      = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_ANY_CHK;
                end
            end
            S_ANY_CHK: begin
                if (i_stat.nonzero) begin
                    cmd.stage_hdr1 = 1'b1;
                    cmd.phase2     = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    cmd.adv = 1'b1;
                    n_state = S_ANY_RD;
                end
            end
            S_COL_RD: begin
                cmd.col = 1'b1;
                if (i_stat.at_end) begin
                    // nothing left under the current dimensions: drop the fetch
                    cmd.clear = 1'b1;
                    n_state   = S_IDLE;
                end else if (!i_stat.in_range) begin
                    cmd.adv = 1'b1;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_COL_CHK;
                end
            end
            S_COL_CHK: begin
                cmd.col = 1'b1;
                cmd.adv = 1'b1;
                if (i_stat.nonzero) begin
                    cmd.stage_elem = 1'b1;
                    n_state        = S_NXT_RD;
                end else begin
                    n_state = S_COL_RD;
                end
            end
            S_NXT_RD: begin
                cmd.col = 1'b1;
                if (i_stat.at_end) begin
                    cmd.mark_last = 1'b1;
                    cmd.clear     = 1'b1;
                    n_state       = S_EMIT;
                end else if (!i_stat.in_range) begin
                    cmd.adv = 1'b1;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_NXT_CHK;
                end
            end
            S_NXT_CHK: begin
                cmd.col = 1'b1;
                if (i_stat.nonzero) begin
                    n_state = S_EMIT;
                end else begin
                    cmd.adv = 1'b1;
                    n_state = S_NXT_RD;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
endmodule

// ===== rtl/core/sparse_matrix_triplet_transpose_core.sv =====
// Load beat: taken while idle. Header fetch: staged, then moved into the output register.
// Element fetch: the serial split of the saved scan position (POS_W = clog2(MAX_DIM^2+1), 13 by
// default), then a read state and a check state per store entry visited through the single read
// port, plus the look-ahead to the next nonzero for the last flag of the transposed list.
// Reset (i_rst_n low, synchronous) returns to the loading phase with cleared counters and
// dimensions of one; the store is not cleared and needs no pass.
`include "sparse_matrix_triplet_transpose_core_defines.svh"

module sparse_matrix_triplet_transpose_core import smtt_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    smtt_in_if.sink               i_in,
    smtt_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic [DIM_W-1:0] r_num_rows, r_num_cols;
    logic             reg_sel;
    logic             cfg_wr;
    logic             in_ready;
    logic             last_beat;
    logic             early_fetch;
    t_cmd             cmd;
    t_stat            stat;

    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_W'(1);
            r_num_cols <= DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_NUM_ROWS: r_num_rows <= pwdata[DIM_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NUM_ROWS: prdata = APB_DATA_W'(r_num_rows);
            REG_NUM_COLS: prdata = APB_DATA_W'(r_num_cols);
        endcase
    end

    smtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    smtt_dp #(
        .MAX_DIM     (MAX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_num_rows     (r_num_rows),
        .i_num_cols     (r_num_cols),
        .i_elem_value   (i_in.elem_value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_list_id      (o_out.list_id),
        .o_is_header    (o_out.is_header),
        .o_first_coord  (o_out.first_coord),
        .o_second_coord (o_out.second_coord),
        .o_entry_value  (o_out.entry_value),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;

    assign last_beat   = o_out.valid && o_out.last;
    assign early_fetch = i_in.valid && in_ready && (i_in.op == OP_FETCH)
                         && (stat.phase == PH_LOAD) && !stat.load_full;

    // the final result only ever enters the output register after the block cleared itself
    `SMTT_ASSERT_SAME(a_last_after_clear, i_clk, i_rst_n, $rose(last_beat), stat.phase == PH_LOAD)
    `SMTT_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, cmd.emit, o_out.valid)
    `SMTT_ASSERT_NEXT(a_early_fetch_idle, i_clk, i_rst_n, early_fetch, in_ready)
    `SMTT_ASSERT_SAME(a_scan_busy, i_clk, i_rst_n, cmd.rd, !in_ready)
endmodule

// ===== tb/smtt_triplet_checker.sv =====
// Scoreboard for the sparse matrix triplet transpose core: watches both channels and the
// register port, predicts every result beat and compares it field by field.
// Depends on smtt_pkg and the smtt_in_if / smtt_out_if interfaces.
module smtt_triplet_checker import smtt_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    smtt_in_if                    i_in,
    smtt_out_if                   i_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int NOT_FOUND   = -1;

    typedef struct packed {
        logic                     list_id;
        logic                     is_header;
        logic [DIM_W-1:0]         first_coord;
        logic [DIM_W-1:0]         second_coord;
        logic signed [ELEM_W-1:0] entry_value;
        logic                     last;
    } t_triplet;

    logic signed [ELEM_W-1:0] dense_matrix [STORE_DEPTH];
    int                       loaded;
    int                       nz_total;
    t_phase                   phase;
    int                       scan_at;
    logic [DIM_W-1:0]         rows_reg;
    logic [DIM_W-1:0]         cols_reg;
    t_triplet                 pending_triplets [$];
    int                       fails = 0;

    function automatic int dim_in_use(input logic [DIM_W-1:0] raw);
        if (raw == '0) return 1;
        if (int'(raw) > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic void restart_lists();
        loaded   = 0;
        nz_total = 0;
        phase    = PH_LOAD;
        scan_at  = 0;
    endfunction

    function automatic t_triplet pack_triplet(input logic list, input logic hdr, input int a,
                                              input int b, input logic signed [ELEM_W-1:0] v,
                                              input logic fin);
        t_triplet t;
        t.list_id      = list;
        t.is_header    = hdr;
        t.first_coord  = DIM_W'(a);
        t.second_coord = DIM_W'(b);
        t.entry_value  = v;
        t.last         = fin;
        return t;
    endfunction

    // Only entries below both the load count and the live matrix size are listed.
    function automatic int next_row_major(input int from);
        int limit;
        limit = dim_in_use(rows_reg) * dim_in_use(cols_reg);
        if (loaded < limit) limit = loaded;
        for (int i = from; i < limit && i < STORE_DEPTH; i++)
            if (dense_matrix[i] != 0) return i;
        return NOT_FOUND;
    endfunction

    // Returns the column-major scan index of the next listed nonzero.
    function automatic int next_col_major(input int from);
        int r;
        int c;
        int idx;
        r = dim_in_use(rows_reg);
        c = dim_in_use(cols_reg);
        for (int p = from; p < r * c; p++) begin
            idx = (p % r) * c + p / r;
            if (idx < loaded && idx < STORE_DEPTH && dense_matrix[idx] != 0) return p;
        end
        return NOT_FOUND;
    endfunction

    // Apply one request beat; returns 1 when it produces a result beat.
    function automatic bit advance_triplet_lists(input logic op,
                                                 input logic signed [ELEM_W-1:0] v,
                                                 output t_triplet t);
        int r;
        int c;
        int pos;
        int nxt;
        r = dim_in_use(rows_reg);
        c = dim_in_use(cols_reg);
        t = '0;
        if (op == OP_LOAD) begin
            // Values at the full 32-bit width need no saturation.
            if (phase == PH_LOAD && loaded < r * c && loaded < STORE_DEPTH) begin
                dense_matrix[loaded] = v;
                if (v != 0) nz_total++;
                loaded++;
            end
            return 1'b0;
        end
        case (phase)
            PH_LOAD: begin
                if (loaded < r * c) return 1'b0;
                t = pack_triplet(1'b0, 1'b1, r, c, ELEM_W'(nz_total), 1'b0);
                phase   = PH_ROW;
                scan_at = 0;
                return 1'b1;
            end
            PH_ROW: begin
                pos = next_row_major(scan_at);
                if (pos != NOT_FOUND) begin
                    t = pack_triplet(1'b0, 1'b0, pos / c, pos % c, dense_matrix[pos], 1'b0);
                    scan_at = pos + 1;
                    return 1'b1;
                end
                if (next_col_major(0) == NOT_FOUND) begin
                    t = pack_triplet(1'b1, 1'b1, c, r, ELEM_W'(nz_total), 1'b1);
                    restart_lists();
                end else begin
                    t = pack_triplet(1'b1, 1'b1, c, r, ELEM_W'(nz_total), 1'b0);
                    phase   = PH_COL;
                    scan_at = 0;
                end
                return 1'b1;
            end
            PH_COL: begin
                pos = next_col_major(scan_at);
                if (pos == NOT_FOUND) begin
                    restart_lists();
                    return 1'b0;
                end
                nxt = next_col_major(pos + 1);
                t = pack_triplet(1'b1, 1'b0, pos / r, pos % r,
                                 dense_matrix[(pos % r) * c + pos / r], nxt == NOT_FOUND);
                if (nxt == NOT_FOUND) restart_lists();
                else scan_at = pos + 1;
                return 1'b1;
            end
            default: begin
                restart_lists();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic compare_field(input string what, input logic signed [63:0] want_v,
                                 input logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_triplet want;
        t_triplet made;
        if (!i_rst_n) begin
            restart_lists();
            rows_reg = DIM_W'(1);
            cols_reg = DIM_W'(1);
            pending_triplets.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[CFG_ADDR_W-1:2] == REG_NUM_ROWS) rows_reg = i_pwdata[DIM_W-1:0];
                else if (i_paddr[CFG_ADDR_W-1:2] == REG_NUM_COLS)
                    cols_reg = i_pwdata[DIM_W-1:0];
            end
            // Retire the result beat before queuing a new one: a result never
            // leaves on the edge that accepts its request.
            if (i_out.valid && i_out.ready) begin
                if (pending_triplets.size() == 0) begin
                    $display("%0t ns: unexpected result beat, list %0d hdr %0d (%0d,%0d) %0d",
                             $time, i_out.list_id, i_out.is_header, i_out.first_coord,
                             i_out.second_coord, i_out.entry_value);
                    fails++;
                end else begin
                    want = pending_triplets.pop_front();
                    compare_field("list_id", want.list_id, i_out.list_id);
                    compare_field("is_header", want.is_header, i_out.is_header);
                    compare_field("first_coord", want.first_coord, i_out.first_coord);
                    compare_field("second_coord", want.second_coord, i_out.second_coord);
                    compare_field("entry_value", want.entry_value, i_out.entry_value);
                    compare_field("last", want.last, i_out.last);
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (advance_triplet_lists(i_in.op, i_in.elem_value, made))
                    pending_triplets.push_back(made);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_triplets.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the triplet transpose testbench: clock, reset, request and register stimulus,
// result-side stalls and the verdict.
// Depends on smtt_pkg, the channel interfaces, the core and smtt_triplet_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smtt_pkg::*;

    localparam int ITEM_TARGET = 500;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    int send_idle_pct = 15;
    int recv_idle_pct = 85;
    int cur_rows      = 1;
    int cur_cols      = 1;
    int items_done    = 0;

    smtt_in_if  in_ch ();
    smtt_out_if out_ch ();

    sparse_matrix_triplet_transpose_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    smtt_triplet_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Hold valid until the beat is taken; valid stays up for a following beat.
    task automatic send_beat(input logic op, input logic signed [ELEM_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.elem_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Drain, then give a scan with no result time to run out before touching registers.
    task automatic settle();
        wait_results();
        repeat (4 * cur_rows * cur_cols + 40) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic sel, input logic [DIM_W-1:0] raw);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF80) | APB_DATA_W'(raw);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Out-of-range encodings are picked at random for the clamped sizes.
    function automatic logic [DIM_W-1:0] raw_for(input int acting);
        if (acting == 1) return $urandom_range(1) ? DIM_W'(1) : DIM_W'(0);
        if (acting == MAX_DIM_DEF) begin
            case ($urandom_range(3))
                0: return DIM_W'(MAX_DIM_DEF);
                1: return DIM_W'(MAX_DIM_DEF + 1);
                2: return DIM_W'(100);
                default: return '1;
            endcase
        end
        return DIM_W'(acting);
    endfunction

    task automatic set_shape(input int rows, input int cols);
        settle();
        write_cfg(REG_NUM_ROWS, raw_for(rows));
        write_cfg(REG_NUM_COLS, raw_for(cols));
        cur_rows = rows;
        cur_cols = cols;
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value(input int zero_pct);
        if ($urandom_range(99) < zero_pct) return '0;
        case ($urandom_range(7))
            0: return {1'b1, {(ELEM_W-1){1'b0}}};
            1: return {1'b0, {(ELEM_W-1){1'b1}}};
            2: return '1;
            3: return ELEM_W'(1);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int n_fetch;
        int nz;
        int zero_pct;
        int pick;
        logic signed [ELEM_W-1:0] v;

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_LOAD;
        in_ch.elem_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 1x1 out of reset: fetch too early, largest value, load past the end.
        send_beat(OP_FETCH, $urandom());
        send_beat(OP_LOAD, {1'b0, {(ELEM_W-1){1'b1}}});
        send_beat(OP_LOAD, ELEM_W'(5));
        repeat (4) send_beat(OP_FETCH, $urandom());

        // All-zero matrix: the transposed header closes the lists.
        set_shape(1, 2);
        repeat (2) send_beat(OP_LOAD, '0);
        repeat (2) send_beat(OP_FETCH, $urandom());

        // Shrink the size after the transposed header so the column scan finds nothing.
        set_shape(2, 3);
        send_beat(OP_LOAD, '0);
        send_beat(OP_LOAD, {1'b1, {(ELEM_W-1){1'b0}}});
        repeat (3) send_beat(OP_LOAD, '0);
        send_beat(OP_LOAD, '1);
        repeat (4) send_beat(OP_FETCH, $urandom());
        set_shape(1, 1);
        send_beat(OP_FETCH, $urandom());

        while (items_done < ITEM_TARGET) begin
            if (items_done < ITEM_TARGET / 3) begin
                send_idle_pct = 15;
                recv_idle_pct = 85;
            end else if (items_done < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Mostly small matrices; a few long thin ones reach the largest size.
            pick = $urandom_range(99);
            if (pick < 4) set_shape(MAX_DIM_DEF, $urandom_range(2, 1));
            else if (pick < 8) set_shape($urandom_range(2, 1), MAX_DIM_DEF);
            else set_shape($urandom_range(6, 1), $urandom_range(6, 1));

            case ($urandom_range(3))
                0: zero_pct = 0;
                1: zero_pct = 50;
                2: zero_pct = 80;
                default: zero_pct = 100;
            endcase

            nz = 0;
            for (int k = 0; k < cur_rows * cur_cols; k++) begin
                if ($urandom_range(99) < 4) send_beat(OP_FETCH, $urandom());
                v = pick_value(zero_pct);
                if (v != 0) nz++;
                send_beat(OP_LOAD, v);
                items_done++;
            end
            if ($urandom_range(99) < 10) send_beat(OP_LOAD, $urandom());

            n_fetch = 2 * nz + 2;
            for (int k = 0; k < n_fetch; k++) begin
                send_beat(OP_FETCH, $urandom());
                items_done++;
                // Loads between fetches are dropped; never after the closing fetch.
                if (k < n_fetch - 1 && $urandom_range(99) < 5) send_beat(OP_LOAD, $urandom());
                if ($urandom_range(99) < 3) wait_results();
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/smtt_pkg.sv
rtl/core/smtt_in_if.sv
rtl/core/smtt_out_if.sv
rtl/core/smtt_div.sv
rtl/core/smtt_dp.sv
rtl/core/smtt_ctrl.sv
rtl/core/sparse_matrix_triplet_transpose_core.sv
tb/smtt_triplet_checker.sv
tb/tb.sv
